// ===== rtl/core/wam_pkg.sv =====
package wam_pkg;

	localparam int SampleBits = 16;
	localparam int CountBits  = 17;
	localparam int SumBits    = 33;
	localparam int SqBits     = 47;
	localparam int DvdBits    = 64;
	localparam int DsrBits    = 35;
	localparam int OutBits    = 120;
	localparam logic [15:0] Sqrt2Q15 = 16'd46341;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NO_SIGNAL = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

	typedef struct packed {
		logic [CountBits-1:0]         n;
		logic signed [SumBits-1:0]    sum;
		logic [SqBits-1:0]            sumsq;
		logic signed [SampleBits-1:0] smin;
		logic signed [SampleBits-1:0] smax;
		logic                         ovf;
	} wam_snap_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_NUM,
		ST_DIV_MS,
		ST_SQ_RMS,
		ST_DIV_AC,
		ST_SQ_AC,
		ST_DIV_DC,
		ST_DIV_CF,
		ST_FIN
	} wam_state_t;

endpackage

// ===== rtl/core/wam_front.sv =====
module wam_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	input  logic signed [15:0]  in_sample,
	input  logic                q_full,
	output logic                in_ready,
	output logic                push,
	output wam_pkg::wam_snap_t  push_data
);

	logic [wam_pkg::CountBits-1:0]         cnt_q;
	logic signed [wam_pkg::SumBits-1:0]    sum_q;
	logic [wam_pkg::SqBits-1:0]            sq_q;
	logic signed [wam_pkg::SampleBits-1:0] min_q;
	logic signed [wam_pkg::SampleBits-1:0] max_q;
	logic                                  ovf_q;
	logic signed [31:0]                    prod;
	logic                                  accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && in_last;
	assign prod     = in_sample * in_sample;

	always_comb begin
		push_data.n     = cnt_q;
		push_data.sum   = sum_q;
		push_data.sumsq = sq_q;
		push_data.smin  = min_q;
		push_data.smax  = max_q;
		push_data.ovf   = ovf_q;
		if (cnt_q[wam_pkg::CountBits-1]) begin
			push_data.ovf = 1'b1;
		end else begin
			push_data.n     = cnt_q + 1'b1;
			push_data.sum   = sum_q + 33'(in_sample);
			push_data.sumsq = sq_q + {15'd0, $unsigned(prod)};
			if (in_sample < min_q) begin
				push_data.smin = in_sample;
			end
			if (in_sample > max_q) begin
				push_data.smax = in_sample;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			sq_q  <= '0;
			min_q <= 16'sh7fff;
			max_q <= 16'sh8000;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				cnt_q <= '0;
				sum_q <= '0;
				sq_q  <= '0;
				min_q <= 16'sh7fff;
				max_q <= 16'sh8000;
				ovf_q <= 1'b0;
			end else begin
				cnt_q <= push_data.n;
				sum_q <= push_data.sum;
				sq_q  <= push_data.sumsq;
				min_q <= push_data.smin;
				max_q <= push_data.smax;
				ovf_q <= push_data.ovf;
			end
		end
	end

endmodule

// ===== rtl/core/wam_fifo.sv =====
module wam_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wam_pkg::wam_snap_t push_data,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output wam_pkg::wam_snap_t pop_data
);

	wam_pkg::wam_snap_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/core/wam_div.sv =====
module wam_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wam_pkg::DvdBits-1:0]  dividend,
	input  logic [wam_pkg::DsrBits-1:0]  divisor,
	output logic                         busy,
	output logic [wam_pkg::DvdBits-1:0]  quotient,
	output logic [wam_pkg::DsrBits-1:0]  remainder
);

	logic [wam_pkg::DvdBits-1:0] dvd_q;
	logic [wam_pkg::DsrBits-1:0] dsr_q;
	logic [wam_pkg::DsrBits-1:0] rem_q;
	logic [5:0]                  cnt_q;
	logic                        busy_q;
	logic [wam_pkg::DsrBits:0]   rem_sh;
	logic                        ge;

	assign busy      = busy_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;
	assign rem_sh    = {rem_q, dvd_q[wam_pkg::DvdBits-1]};
	assign ge        = (rem_sh >= {1'b0, dsr_q});

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 35'(rem_sh - {1'b0, dsr_q}) : rem_sh[wam_pkg::DsrBits-1:0];
			dvd_q <= {dvd_q[wam_pkg::DvdBits-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 6'd63) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/wam_back.sv =====
module wam_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         snap_avail,
	input  wam_pkg::wam_snap_t           snap,
	output logic                         pop,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [wam_pkg::OutBits-1:0]  res_data
);

	wam_pkg::wam_state_t state_q, state_nx;

	logic [16:0] n_q;
	logic [31:0] mag_q;
	logic        neg_q;
	logic [46:0] sumsq_q;
	logic [16:0] peak_q;
	logic [15:0] p2p_q;
	logic        ovf_q;
	logic [40:0] plo_q;
	logic [39:0] phi_q;
	logic [63:0] msq_q;
	logic [33:0] den_q;
	logic [63:0] num_q;
	logic [15:0] rms_q;
	logic [15:0] ac_q;
	logic [15:0] dc_q;
	logic [15:0] crest_q;
	logic        launched_q;
	logic        res_valid_q;
	logic [wam_pkg::OutBits-1:0] res_q;

	logic        div_start;
	logic [63:0] div_dvd;
	logic [34:0] div_dsr;
	logic        div_busy;
	logic [63:0] div_quo;
	logic [34:0] div_rem;

	logic        sq_start;
	logic        sq_busy_q;
	logic [4:0]  sq_cnt_q;
	logic [63:0] sq_v_q;
	logic [63:0] sq_r_q;
	logic [63:0] sq_b_q;
	logic [63:0] sq_t;

	logic        unit_done;
	logic        out_load;
	logic [31:0] sine_full;
	logic [16:0] abs_min;
	logic [16:0] abs_max;
	logic [32:0] neg_sum;
	logic [16:0] dc_mag;
	logic [15:0] dc_nx;

	wam_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign res_valid = res_valid_q;
	assign res_data  = res_q;
	assign unit_done = launched_q && !div_busy && !sq_busy_q;
	assign sq_t      = sq_r_q + sq_b_q;
	assign sine_full = ac_q * wam_pkg::Sqrt2Q15;
	assign abs_min   = snap.smin[15] ? 17'(-18'(snap.smin)) : 17'(snap.smin);
	assign abs_max   = snap.smax[15] ? 17'(-18'(snap.smax)) : 17'(snap.smax);
	assign neg_sum   = -snap.sum;
	assign dc_mag    = div_quo[16:0] + 17'(div_rem != '0);
	assign dc_nx     = neg_q ? 16'(-dc_mag) : div_quo[15:0];

	always_comb begin
		state_nx  = state_q;
		pop       = 1'b0;
		div_start = 1'b0;
		div_dvd   = 64'(sumsq_q);
		div_dsr   = 35'(n_q);
		sq_start  = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			wam_pkg::ST_IDLE: begin
				if (snap_avail) begin
					pop      = 1'b1;
					state_nx = wam_pkg::ST_MUL1;
				end
			end
			wam_pkg::ST_MUL1: state_nx = wam_pkg::ST_MUL2;
			wam_pkg::ST_MUL2: state_nx = wam_pkg::ST_NUM;
			wam_pkg::ST_NUM:  state_nx = wam_pkg::ST_DIV_MS;
			wam_pkg::ST_DIV_MS: begin
				div_start = !launched_q;
				if (unit_done) begin
					state_nx = wam_pkg::ST_SQ_RMS;
				end
			end
			wam_pkg::ST_SQ_RMS: begin
				sq_start = !launched_q;
				if (unit_done) begin
					state_nx = wam_pkg::ST_DIV_AC;
				end
			end
			wam_pkg::ST_DIV_AC: begin
				div_dvd   = num_q;
				div_dsr   = 35'(den_q);
				div_start = !launched_q;
				if (unit_done) begin
					state_nx = wam_pkg::ST_SQ_AC;
				end
			end
			wam_pkg::ST_SQ_AC: begin
				sq_start = !launched_q;
				if (unit_done) begin
					state_nx = wam_pkg::ST_DIV_DC;
				end
			end
			wam_pkg::ST_DIV_DC: begin
				div_dvd   = 64'(mag_q);
				div_start = !launched_q;
				if (unit_done) begin
					state_nx = wam_pkg::ST_DIV_CF;
				end
			end
			wam_pkg::ST_DIV_CF: begin
				div_dvd = 64'({peak_q, 8'd0});
				div_dsr = 35'(rms_q);
				if (rms_q == '0) begin
					state_nx = wam_pkg::ST_FIN;
				end else begin
					div_start = !launched_q;
					if (unit_done) begin
						state_nx = wam_pkg::ST_FIN;
					end
				end
			end
			wam_pkg::ST_FIN: begin
				if (!res_valid_q || res_ready) begin
					out_load = 1'b1;
					state_nx = wam_pkg::ST_IDLE;
				end
			end
			default: state_nx = wam_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wam_pkg::ST_IDLE;
			launched_q  <= 1'b0;
			res_valid_q <= 1'b0;
			sq_busy_q   <= 1'b0;
			sq_cnt_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (div_start || sq_start) begin
				launched_q <= 1'b1;
			end else if (unit_done) begin
				launched_q <= 1'b0;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (sq_start) begin
				sq_busy_q <= 1'b1;
				sq_cnt_q  <= '0;
			end else if (sq_busy_q) begin
				sq_cnt_q <= sq_cnt_q + 1'b1;
				if (sq_cnt_q == 5'd31) begin
					sq_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sq_start) begin
			sq_v_q <= div_quo;
			sq_r_q <= '0;
			sq_b_q <= 64'd1 << 62;
		end else if (sq_busy_q) begin
			if (sq_v_q >= sq_t) begin
				sq_v_q <= sq_v_q - sq_t;
				sq_r_q <= (sq_r_q >> 1) + sq_b_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_b_q <= sq_b_q >> 2;
		end
		if (pop) begin
			n_q     <= snap.n;
			neg_q   <= snap.sum[32];
			mag_q   <= snap.sum[32] ? neg_sum[31:0] : snap.sum[31:0];
			sumsq_q <= snap.sumsq;
			peak_q  <= (abs_min > abs_max) ? abs_min : abs_max;
			p2p_q   <= 16'(snap.smax - snap.smin);
			ovf_q   <= snap.ovf;
		end
		if (state_q == wam_pkg::ST_MUL1) begin
			plo_q <= n_q * sumsq_q[23:0];
			msq_q <= mag_q * mag_q;
			den_q <= n_q * n_q;
		end
		if (state_q == wam_pkg::ST_MUL2) begin
			phi_q <= n_q * sumsq_q[46:24];
		end
		if (state_q == wam_pkg::ST_NUM) begin
			num_q <= {phi_q, 24'd0} + 64'(plo_q) - msq_q;
		end
		if (unit_done && state_q == wam_pkg::ST_SQ_RMS) begin
			rms_q <= sq_r_q[15:0];
		end
		if (unit_done && state_q == wam_pkg::ST_SQ_AC) begin
			ac_q <= sq_r_q[15:0];
		end
		if (unit_done && state_q == wam_pkg::ST_DIV_DC) begin
			dc_q <= dc_nx;
		end
		if (state_q == wam_pkg::ST_DIV_CF) begin
			if (rms_q == '0) begin
				crest_q <= '0;
			end else if (unit_done) begin
				crest_q <= (div_quo > 64'd65535) ? 16'hffff : div_quo[15:0];
			end
		end
		if (out_load) begin
			res_q <= {6'd0,
				ovf_q ? wam_pkg::STATUS_TOO_LONG :
				((rms_q == '0) ? wam_pkg::STATUS_NO_SIGNAL : wam_pkg::STATUS_OK),
				sine_full[30:15], crest_q, peak_q[15:0], p2p_q, dc_q, ac_q, rms_q};
		end
	end

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy && !sq_busy_q)
		else $error("divider launched while a unit is busy");

	a_sq_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !div_busy && !sq_busy_q)
		else $error("square root launched while a unit is busy");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wam_pkg::ST_IDLE |-> !div_busy && !sq_busy_q && !launched_q)
		else $error("unit still running in idle");

	a_no_crest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && rms_q == '0) |=> res_q[95:80] == '0)
		else $error("crest factor nonzero without signal");

endmodule

// ===== rtl/core/window_amplitude_measurement_core.sv =====
// Window amplitude meter (RMS, AC RMS, DC, peak-to-peak, peak, crest, sine peak).
// Input channel s_*: one signed 16-bit sample per beat in s_tdata[15:0];
// s_tlast marks the final sample of a measurement window.
// Output channel m_*: one result beat per window, sent after the window's
// last sample.
// Samples are taken one per cycle; a two-entry queue holds the totals of
// finished windows, and s_tready drops only while that queue is full.
// The back end works out one window in order: pop, the MUL1 and MUL2 multiply
// states and the NUM numerator state, then four divides on one shared radix-2
// divider and two roots on a bit-pair square root unit, and an output load.
// With zero RMS the crest divide is skipped. Windows that arrive faster than
// the back end works them out back up into the queue and then stall input.
// A stalled receiver holds the result in the output register; the next
// window's computation finishes and waits in its final state without losing data.
// Reset clears all totals, the queue and the output valid.
module window_amplitude_measurement_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,  // sample
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// rms, ac rms, mean, max minus min, peak magnitude,
	// peak over rms, sine peak, status, zero fill
	output logic [119:0] m_tdata
);

	logic               q_full;
	logic               q_empty;
	logic               push;
	logic               pop;
	wam_pkg::wam_snap_t push_data;
	wam_pkg::wam_snap_t pop_data;

	wam_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_sample ($signed(s_tdata)),
		.q_full    (q_full),
		.in_ready  (s_tready),
		.push      (push),
		.push_data (push_data)
	);

	wam_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.pop_data  (pop_data)
	);

	wam_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_avail (!q_empty),
		.snap       (pop_data),
		.pop        (pop),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_data   (m_tdata)
	);

endmodule

// ===== verif/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxWin = 65536;
	localparam int IdleLimit = 20000;

	typedef struct {
		logic [15:0] sample;
		logic        last;
	} sample_beat_t;

	typedef struct {
		logic [15:0] rms;
		logic [15:0] ac_rms;
		logic [15:0] dc;
		logic [15:0] p2p;
		logic [15:0] peak;
		logic [15:0] crest;
		logic [15:0] sine;
		logic [1:0]  status;
	} meas_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [119:0] m_tdata;

	window_amplitude_measurement_core uut (.*);

	always #2 clk = ~clk;

	sample_beat_t pending[$];
	meas_t        expected_meas[$];
	int           errors = 0;
	int           idle_cycles = 0;
	int           windows_done = 0;
	int           beats_sent = 0;
	bit           hold_rx = 1'b0;
	bit           hold_tx = 1'b0;
	bit           stim_done = 1'b0;
	bit           in_acc = 1'b0;

	// window accumulators
	longint unsigned acc_n;
	longint          acc_sum;
	longint unsigned acc_sq;
	longint          acc_min;
	longint          acc_max;
	bit              acc_ovf;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic clear_window();
		acc_n = 0;
		acc_sum = 0;
		acc_sq = 0;
		acc_min = 32767;
		acc_max = -32768;
		acc_ovf = 1'b0;
	endtask

	task automatic predict_meas(input sample_beat_t b);
		longint          s, dc;
		longint unsigned mag, rms, ac, pk, cr, mn, mx;
		meas_t           m;
		s = longint'($signed(b.sample));
		if (acc_n >= MaxWin) begin
			acc_ovf = 1'b1;
		end else begin
			mag = s < 0 ? -s : s;
			acc_n++;
			acc_sum += s;
			acc_sq += mag * mag;
			if (s < acc_min) acc_min = s;
			if (s > acc_max) acc_max = s;
		end
		if (!b.last) return;
		rms = int_sqrt(acc_sq / acc_n);
		mag = acc_sum < 0 ? -acc_sum : acc_sum;
		ac = int_sqrt((acc_n * acc_sq - mag * mag) / (acc_n * acc_n));
		if (acc_sum >= 0) dc = mag / acc_n;
		else dc = -longint'((mag + acc_n - 1) / acc_n);
		mn = acc_min < 0 ? -acc_min : acc_min;
		mx = acc_max < 0 ? -acc_max : acc_max;
		pk = mn > mx ? mn : mx;
		if (rms == 0) cr = 0;
		else begin
			cr = pk * 256 / rms;
			if (cr > 65535) cr = 65535;
		end
		m.rms = rms[15:0];
		m.ac_rms = ac[15:0];
		m.dc = dc[15:0];
		m.p2p = 16'(acc_max - acc_min);
		m.peak = pk[15:0];
		m.crest = cr[15:0];
		m.sine = 16'((ac * 46341) >> 15);
		m.status = acc_ovf ? wam_pkg::STATUS_TOO_LONG :
			(rms == 0 ? wam_pkg::STATUS_NO_SIGNAL : wam_pkg::STATUS_OK);
		expected_meas.push_back(m);
		clear_window();
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 60) return 0;
		if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 15)) - 16'd8;
			3: return 16'($urandom_range(0, 65535)) & 16'h00ff;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic add_beat(input logic [15:0] v, input logic l);
		sample_beat_t b;
		b.sample = v;
		b.last = l;
		pending.push_back(b);
	endtask

	task automatic add_window(input int len);
		for (int i = 0; i < len; i++) add_beat(rand_sample(), i == len - 1);
	endtask

	// driver
	int tx_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_acc) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending.size() > 0 && !hold_tx) begin
					sample_beat_t b;
					b = pending.pop_front();
					s_tdata <= b.sample;
					s_tlast <= b.last;
					s_tvalid <= 1'b1;
					tx_gap = gap_len();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) m_tready <= hold_rx ? 1'b0 : ($urandom_range(0, 99) < 70);
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			in_acc = s_tvalid && s_tready;
			if (in_acc) begin
				predict_meas('{sample: s_tdata, last: s_tlast});
				beats_sent++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (m_tvalid && m_tready) begin
				meas_t m;
				windows_done++;
				if (expected_meas.size() == 0) begin
					report_mismatch("unexpected beat", m_tdata[15:0], 16'd0);
				end else begin
					m = expected_meas.pop_front();
					if (m_tdata[15:0] !== m.rms) report_mismatch("rms", m_tdata[15:0], m.rms);
					if (m_tdata[31:16] !== m.ac_rms)
						report_mismatch("ac_rms", m_tdata[31:16], m.ac_rms);
					if (m_tdata[47:32] !== m.dc) report_mismatch("dc", m_tdata[47:32], m.dc);
					if (m_tdata[63:48] !== m.p2p) report_mismatch("p2p", m_tdata[63:48], m.p2p);
					if (m_tdata[79:64] !== m.peak)
						report_mismatch("peak", m_tdata[79:64], m.peak);
					if (m_tdata[95:80] !== m.crest)
						report_mismatch("crest", m_tdata[95:80], m.crest);
					if (m_tdata[111:96] !== m.sine)
						report_mismatch("sine", m_tdata[111:96], m.sine);
					if (m_tdata[113:112] !== m.status)
						report_mismatch("status", 16'(m_tdata[113:112]), 16'(m.status));
				end
			end
			if (idle_cycles >= IdleLimit) begin
				$display("timeout at %0t", $realtime);
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		clear_window();
		// directed windows
		add_beat(16'h0000, 1'b1);
		add_beat(16'h7fff, 1'b1);
		add_beat(16'h8000, 1'b1);
		add_beat(16'h8000, 1'b0);
		add_beat(16'h7fff, 1'b1);
		add_beat(16'h0001, 1'b0);
		add_beat(16'hffff, 1'b1);
		add_beat(16'hfffd, 1'b0);
		add_beat(16'hfffe, 1'b0);
		add_beat(16'hfffe, 1'b1);
		add_beat(16'h0064, 1'b0);
		add_beat(16'h0000, 1'b0);
		add_beat(16'h0000, 1'b0);
		add_beat(16'h0000, 1'b1);
		add_beat(16'h5555, 1'b0);
		add_beat(16'haaaa, 1'b1);
		add_beat(16'h1234, 1'b0);
		add_beat(16'h1234, 1'b1);
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		wait (pending.size() == 0);
		// pause until drained
		hold_tx = 1'b1;
		wait (expected_meas.size() == 0 && !s_tvalid);
		hold_tx = 1'b0;
		// hold receiver off while short windows back up
		hold_rx = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_rx = 1'b0;
			end
		join_none
		for (int i = 0; i < 12; i++) add_window($urandom_range(1, 3));
		wait (!hold_rx);
		// random windows, mostly short
		while (beats_sent < 380) begin
			add_window($urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8));
			wait (pending.size() < 4);
		end
		wait (pending.size() == 0);
		wait (expected_meas.size() == 0 && !s_tvalid);
		repeat (400) @(posedge clk);
		$display("covered %0d sample beats in %0d windows, edge and random values",
			beats_sent, windows_done);
		$display("held receiver off and drained sender once each");
		if (errors == 0) $display("tb OK");
		else $display("tb NOT OK");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/wam_pkg.sv
rtl/core/wam_front.sv
rtl/core/wam_fifo.sv
rtl/core/wam_div.sv
rtl/core/wam_back.sv
rtl/core/window_amplitude_measurement_core.sv
verif/tb.sv
